// ===== hw/rtl/mqf_pkg.sv =====
// shared types and constants for the multi-queue message fifo
`timescale 1ns / 1ps
package mqf_pkg;

  localparam int FUNC_W = 2;
  localparam int SEL_W  = 2;
  localparam int ID_W   = 8;
  localparam int DATA_W = 64;
  localparam int OCC_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_QUERY = 2'd2
  } func_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  // pointer advance requests for the selected queue
  typedef struct packed {
    logic adv_head;
    logic adv_tail;
  } ptr_upd_t;

endpackage

// ===== hw/rtl/mqf_ptr_table.sv =====
// head and tail pointer table, one pair per queue, with wrap logic
`timescale 1ns / 1ps
module mqf_ptr_table import mqf_pkg::*; #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_SLOTS = 16,
  parameter int QW = 1,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [QW-1:0] qidx_i,
  input  ptr_upd_t      upd_i,
  output logic [PW-1:0] head_o,
  output logic [PW-1:0] tail_o,
  output logic [PW-1:0] nxt_head_o,
  output logic [PW-1:0] nxt_tail_o
);

  localparam logic [PW-1:0] LastSlot = PW'(QUEUE_SLOTS - 1);

  logic [PW-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0] tail_q [NUM_QUEUES];

  assign head_o     = head_q[qidx_i];
  assign tail_o     = tail_q[qidx_i];
  assign nxt_head_o = (head_o == LastSlot) ? '0 : head_o + PW'(1);
  assign nxt_tail_o = (tail_o == LastSlot) ? '0 : tail_o + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      if (upd_i.adv_head) head_q[qidx_i] <= nxt_head_o;
      if (upd_i.adv_tail) tail_q[qidx_i] <= nxt_tail_o;
    end
  end

endmodule

// ===== hw/rtl/mqf_msg_mem.sv =====
// shared message store: one write port, one read port, registered read data
`timescale 1ns / 1ps
module mqf_msg_mem #(
  parameter int AW = 6,
  parameter int DW = 72
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/multi_queue_message_fifo.sv =====
// Bank of NUM_QUEUES circular message queues sharing one message memory of
// NUM_QUEUES x QUEUE_SLOTS entries, each queue holding at most QUEUE_SLOTS-1
// messages. Every beat on the input yields exactly one result beat. Push,
// query, and any beat to a refused or absent queue load their result
// directly into the output register; a pop that finds a message waits in
// the read state for the registered read data of the message memory.
// Results sit in that register; the next beat is taken only in a cycle
// where it is empty or its result is being taken, never while a pop waits.
// Pointers are cleared by reset; no clearing pass runs over the memory.
`timescale 1ns / 1ps
module multi_queue_message_fifo import mqf_pkg::*; #(
  parameter int NUM_QUEUES    = 4,
  parameter int QUEUE_SLOTS   = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [SEL_W-1:0]  queue_sel_i,
  input  logic [ID_W-1:0]   msg_id_i,
  input  logic [DATA_W-1:0] msg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [ID_W-1:0]   out_id_o,
  output logic [DATA_W-1:0] out_data_o,
  output logic              has_message_o,
  output logic [OCC_W-1:0]  occupancy_o
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int CW = PW + 1;
  localparam int DW = 8 * PAYLOAD_BYTES;
  localparam int MW = ID_W + DW;

  state_e state_q, state_d;

  logic          accept, sel_ok, is_push, is_pop, full, empty;
  logic [QW-1:0] qidx;
  logic [PW-1:0] head, tail, nxt_head, nxt_tail, post_head, post_tail;
  logic [CW-1:0] diff, occ_full;
  logic          has_now;
  logic [OCC_W-1:0] occ_now;
  ptr_upd_t      upd;
  logic [MW-1:0] rd_data;

  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [ID_W-1:0]   id_q;
  logic [DATA_W-1:0] data_q;
  logic              has_q, pend_has_q;
  logic [OCC_W-1:0]  occ_q, pend_occ_q;

  assign accept  = in_valid_i && in_ready_o;
  assign sel_ok  = 32'(queue_sel_i) < NUM_QUEUES;
  assign qidx    = QW'(queue_sel_i);
  assign is_push = func_e'(func_i) == FN_PUSH;
  assign is_pop  = func_e'(func_i) == FN_POP;
  assign full    = nxt_tail == head;
  assign empty   = head == tail;

  assign upd.adv_tail = accept && sel_ok && is_push && !full;
  assign upd.adv_head = accept && sel_ok && is_pop && !empty;

  mqf_ptr_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .QW         (QW),
    .PW         (PW)
  ) u_ptr_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qidx_i    (qidx),
    .upd_i     (upd),
    .head_o    (head),
    .tail_o    (tail),
    .nxt_head_o(nxt_head),
    .nxt_tail_o(nxt_tail)
  );

  mqf_msg_mem #(
    .AW(QW + PW),
    .DW(MW)
  ) u_msg_mem (
    .clk_i  (clk_i),
    .we_i   (upd.adv_tail),
    .waddr_i({qidx, tail}),
    .wdata_i({msg_id_i, msg_data_i[DW-1:0]}),
    .re_i   (upd.adv_head),
    .raddr_i({qidx, head}),
    .rdata_o(rd_data)
  );

  // occupancy of the selected queue after this beat
  assign post_head = upd.adv_head ? nxt_head : head;
  assign post_tail = upd.adv_tail ? nxt_tail : tail;
  assign diff      = {1'b0, post_tail} - {1'b0, post_head};
  assign occ_full  = (post_tail >= post_head) ? diff : diff + CW'(QUEUE_SLOTS);
  assign has_now   = sel_ok && (occ_full != '0);
  assign occ_now   = sel_ok ? OCC_W'(occ_full) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (upd.adv_head) state_d = S_READ;
      S_READ: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (accept && !upd.adv_head) out_valid_d = 1'b1;
      end
      S_READ: out_valid_d = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      ok_q   <= 1'b1;
      id_q   <= rd_data[MW-1:DW];
      data_q <= DATA_W'(rd_data[DW-1:0]);
      has_q  <= pend_has_q;
      occ_q  <= pend_occ_q;
    end else if (accept && !upd.adv_head) begin
      ok_q   <= upd.adv_tail;
      id_q   <= '0;
      data_q <= '0;
      has_q  <= has_now;
      occ_q  <= occ_now;
    end
    // pop status held until the read data returns
    if (upd.adv_head) begin
      pend_has_q <= has_now;
      pend_occ_q <= occ_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign out_id_o      = id_q;
  assign out_data_o    = data_q;
  assign has_message_o = has_q;
  assign occupancy_o   = occ_q;

endmodule

// ===== hw/rtl/mqf_checker.sv =====
// port-level checks for the multi-queue message fifo, bound to the top level
`timescale 1ns / 1ps
module mqf_checker import mqf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              ok_o,
  input logic [ID_W-1:0]   out_id_o,
  input logic [DATA_W-1:0] out_data_o,
  input logic              has_message_o,
  input logic [OCC_W-1:0]  occupancy_o
);

  // a result beat stays until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  // a beat that failed or only queried returns no message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_id_o == '0 && out_data_o == '0)
    else $error("message returned on a beat without ok");

  // a nonzero count means the queue holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && occupancy_o != '0 |-> has_message_o)
    else $error("occupancy and has_message disagree");

  // after an accepted beat either its result is shown or intake is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("beat accepted without result or stall");

endmodule

bind multi_queue_message_fifo mqf_checker u_mqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ok_o         (ok_o),
  .out_id_o     (out_id_o),
  .out_data_o   (out_data_o),
  .has_message_o(has_message_o),
  .occupancy_o  (occupancy_o)
);

// ===== bench/tb_multi_queue_message_fifo.sv =====
// self-checking testbench for the multi-queue message fifo
`timescale 1ns / 1ps
module tb_multi_queue_message_fifo;
  import mqf_pkg::*;

  localparam int NUM_QUEUES    = 4;
  localparam int QUEUE_SLOTS   = 16;
  localparam int PAYLOAD_BYTES = 8;
  localparam logic [DATA_W-1:0] PAYLOAD_MASK =
    (PAYLOAD_BYTES >= 8) ? {DATA_W{1'b1}} : ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);
  // unused code, acts as a query
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic              has_message;
    logic [OCC_W-1:0]  occupancy;
  } fifo_reply_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i        = FN_QUERY;
  logic [SEL_W-1:0]  queue_sel_i   = '0;
  logic [ID_W-1:0]   msg_id_i      = '0;
  logic [DATA_W-1:0] msg_data_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              ok_o;
  logic [ID_W-1:0]   out_id_o;
  logic [DATA_W-1:0] out_data_o;
  logic              has_message_o;
  logic [OCC_W-1:0]  occupancy_o;

  // shadow copy of the queue bank
  int unsigned       head_idx [NUM_QUEUES];
  int unsigned       tail_idx [NUM_QUEUES];
  logic [ID_W-1:0]   id_mem   [NUM_QUEUES*QUEUE_SLOTS];
  logic [DATA_W-1:0] data_mem [NUM_QUEUES*QUEUE_SLOTS];

  fifo_reply_t pending_replies[$];
  int          mismatches      = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  int          burst_left      = 0;

  multi_queue_message_fifo #(
    .NUM_QUEUES   (NUM_QUEUES),
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .queue_sel_i  (queue_sel_i),
    .msg_id_i     (msg_id_i),
    .msg_data_i   (msg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .out_id_o     (out_id_o),
    .out_data_o   (out_data_o),
    .has_message_o(has_message_o),
    .occupancy_o  (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    // cap the printout, keep counting
    if (mismatches < 40)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void predict_queue_op(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] sel,
                                           logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
    fifo_reply_t r;
    int unsigned q;
    int unsigned nxt;
    int unsigned len;
    r = '0;
    q = 32'(sel);
    if (q < NUM_QUEUES) begin
      case (fn)
        FN_PUSH: begin
          nxt = (tail_idx[q] + 1) % QUEUE_SLOTS;
          if (nxt != head_idx[q]) begin
            id_mem[q*QUEUE_SLOTS + tail_idx[q]]   = id;
            data_mem[q*QUEUE_SLOTS + tail_idx[q]] = data & PAYLOAD_MASK;
            tail_idx[q] = nxt;
            r.ok = 1'b1;
          end
        end
        FN_POP: begin
          if (head_idx[q] != tail_idx[q]) begin
            r.id   = id_mem[q*QUEUE_SLOTS + head_idx[q]];
            r.data = data_mem[q*QUEUE_SLOTS + head_idx[q]];
            head_idx[q] = (head_idx[q] + 1) % QUEUE_SLOTS;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      len = (tail_idx[q] + QUEUE_SLOTS - head_idx[q]) % QUEUE_SLOTS;
      r.has_message = (len != 0);
      r.occupancy   = len[OCC_W-1:0];
    end
    pending_replies.push_back(r);
  endfunction

  task automatic send_beat(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] sel,
                           logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
    if (sender_gaps && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    queue_sel_i <= sel;
    msg_id_i    <= id;
    msg_data_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predict_queue_op(fn, sel, id, data);
  endtask

  // hold the input until every reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // receiver: ready runs broken by short stalls
  initial begin
    int run_cnt;
    int stall_cnt;
    run_cnt   = 0;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (receiver_stalls && run_cnt == 0 && stall_cnt == 0) begin
        run_cnt   = $urandom_range(1, 24);
        stall_cnt = $urandom_range(1, 6);
      end
      if (receiver_stalls && stall_cnt != 0) begin
        out_ready_i <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready_i <= 1'b1;
        if (run_cnt != 0) run_cnt--;
      end
    end
  end

  always @(posedge clk_i) begin : check_replies
    fifo_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending", {63'd0, ok_o}, '0);
      end else begin
        want = pending_replies.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", DATA_W'(ok_o), DATA_W'(want.ok));
        if (out_id_o !== want.id)
          report_mismatch("out_id", DATA_W'(out_id_o), DATA_W'(want.id));
        if (out_data_o !== want.data) report_mismatch("out_data", out_data_o, want.data);
        if (has_message_o !== want.has_message)
          report_mismatch("has_message", DATA_W'(has_message_o), DATA_W'(want.has_message));
        if (occupancy_o !== want.occupancy)
          report_mismatch("occupancy", DATA_W'(occupancy_o), DATA_W'(want.occupancy));
      end
    end
  end

  // pop and query on empty queues, plus the spare code
  task automatic test_empty_queues();
    send_beat(FN_POP, 2'd1, 8'hA5, rand_word());
    send_beat(FN_SPARE, 2'd2, 8'h5A, rand_word());
    send_beat(FN_QUERY, 2'd3, 8'hFF, {DATA_W{1'b1}});
  endtask

  // fill queue 0, get refused, pop two, push across the wrap point
  task automatic test_fill_and_wrap();
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
      case (i)
        0:       begin id = 8'hFF; data = {DATA_W{1'b1}}; end
        1:       begin id = 8'h00; data = '0; end
        2:       begin id = 8'h55; data = {16{4'h5}}; end
        3:       begin id = 8'hAA; data = {16{4'hA}}; end
        default: begin id = ID_W'($urandom_range(0, 255)); data = rand_word(); end
      endcase
      send_beat(FN_PUSH, 2'd0, id, data);
    end
    send_beat(FN_PUSH, 2'd0, 8'h3C, rand_word());
    send_beat(FN_QUERY, 2'd0, 8'h00, '0);
    send_beat(FN_POP, 2'd0, 8'h00, '0);
    send_beat(FN_POP, 2'd0, 8'h00, '0);
    send_beat(FN_PUSH, 2'd0, 8'hC3, rand_word());
  endtask

  // chunks lean toward push or pop on a favored queue so queues fill and drain
  task automatic test_random_traffic(int n_items);
    int unsigned push_pct;
    int unsigned r;
    logic [SEL_W-1:0]  favored;
    logic [SEL_W-1:0]  sel;
    logic [FUNC_W-1:0] fn;
    push_pct = 50;
    favored  = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        favored = SEL_W'($urandom_range(0, NUM_QUEUES - 1));
      end
      r = $urandom_range(0, 99);
      if (r < 3)       fn = FN_SPARE;
      else if (r < 10) fn = FN_QUERY;
      else if ($urandom_range(0, 99) < push_pct) fn = FN_PUSH;
      else             fn = FN_POP;
      sel = ($urandom_range(0, 99) < 60) ? favored
                                         : SEL_W'($urandom_range(0, NUM_QUEUES - 1));
      send_beat(fn, sel, ID_W'($urandom_range(0, 255)), rand_word());
    end
  endtask

  // back-to-back beats with the receiver always ready
  task automatic test_full_rate(int n_items);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    test_random_traffic(n_items);
    drain_replies();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_idx[q] = 0;
      tail_idx[q] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queues();
    test_fill_and_wrap();
    drain_replies();
    test_random_traffic(650);
    drain_replies();
    test_full_rate(180);
    test_random_traffic(40);
    drain_replies();

    // let any stray reply show up
    repeat (10) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch("replies still pending", DATA_W'(pending_replies.size()), '0);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== multi_queue_message_fifo.f =====
hw/rtl/mqf_pkg.sv
hw/rtl/mqf_ptr_table.sv
hw/rtl/mqf_msg_mem.sv
hw/rtl/multi_queue_message_fifo.sv
hw/rtl/mqf_checker.sv
bench/tb_multi_queue_message_fifo.sv
